// File: design/ocdt_pkg.sv
// Shared widths, action codes, register indexes and sequencer states of the countdown timer.
package ocdt_pkg;

   // Width of the elapsed count and the duration
   localparam int CNT_W = 32;
   // Width of the percentage and the number of quotient bits it needs
   localparam int PCT_W = 7;
   // Product elapsed * 100 needs this many bits
   localparam int PROD_W = CNT_W + PCT_W;
   // Division steps for the wrap (one-bit-wider sum), and the width of the step counter
   localparam int MOD_STEPS = CNT_W + 1;
   localparam int STEP_W = $clog2(MOD_STEPS + 1);

   localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

   // Input action codes
   localparam logic [2:0] ACT_FRAME = 3'd0;
   localparam logic [2:0] ACT_MS    = 3'd1;
   localparam logic [2:0] ACT_START = 3'd2;
   localparam logic [2:0] ACT_STOP  = 3'd3;
   localparam logic [2:0] ACT_CLEAR = 3'd4;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MSUNIT = 2'd2;

   // Sequencer states
   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_MOD      = 5'b00010,
      S_PCT_LOAD = 5'b00100,
      S_PCT      = 5'b01000,
      S_RESULT   = 5'b10000
   } state_type;

endpackage

// File: design/ocdt_if.sv
// Valid/ready channel interfaces for timer actions and timer status results.
interface ocdt_req_if import ocdt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [2:0]       action;
   logic [CNT_W-1:0] delta_ms;

   modport source (output valid, output action, output delta_ms, input ready);
   modport sink   (input valid, input action, input delta_ms, output ready);
endinterface

interface ocdt_rsp_if import ocdt_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             fired;
   logic             is_running;
   logic             is_expired;
   logic [CNT_W-1:0] elapsed_count;
   logic [CNT_W-1:0] remaining_count;
   logic [PCT_W-1:0] progress_percent;

   modport source (output valid, output fired, output is_running, output is_expired,
                   output elapsed_count, output remaining_count,
                   output progress_percent, input ready);
   modport sink   (input valid, input fired, input is_running, input is_expired,
                   input elapsed_count, input remaining_count,
                   input progress_percent, output ready);
endinterface

// File: design/oneshot_periodic_countdown_timer_top.sv
// Countdown timer, one-shot or repeating, with a serial divider for wrap and progress.
//
// Usage:
//   req_chan carries one action per transfer: frame tick, millisecond advance,
//   start, stop or clear of the elapsed amount. Every action yields exactly one
//   status transfer on rsp_chan (fired, running, expired, elapsed, remaining,
//   progress percent). The csr_ port writes period_length, auto_repeat and
//   millisecond_unit; write them only while no action is in flight.
// Sequencing:
//   One action at a time. A single restoring divide step (compare and subtract
//   against period_length) is reused by the sequencer. An action passes S_PCT_LOAD
//   and S_RESULT when progress is trivially 0 or 100, adds S_PCT for a progress
//   division (7 quotient bits), and adds S_MOD when a repeating millisecond timer
//   reaches its period and the 33-bit sum is reduced modulo the period.
//   req_chan.ready is high only while the sequencer is idle.
// Reset:
//   Synchronous reset clears the control registers and the result slot's valid flag.
// Stall:
//   The result sits in an output register; a new action is taken while it waits.
//   If the receiver still holds off when the next result is done, the sequencer
//   waits until the slot frees.
module oneshot_periodic_countdown_timer_top import ocdt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   ocdt_req_if.sink             req_chan,
   ocdt_rsp_if.source           rsp_chan,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_write_data
);

   // Configuration registers
   logic [CNT_W-1:0] period_ff, period_in;
   logic             repeat_ff, repeat_in;
   logic             msunit_ff, msunit_in;

   // Timer state
   logic [CNT_W-1:0] elapsed_ff, elapsed_in;
   logic             running_ff, running_in;
   logic             expired_ff, expired_in;
   logic             fired_ff, fired_in;

   // Sequencer and shared divide step
   state_type        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W:0]   dvd_ff, dvd_in;
   logic [PCT_W-1:0] quo_ff, quo_in;
   logic [PCT_W-1:0] pct_ff, pct_in;

   // Result slot
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_fired_ff, rsp_fired_in;
   logic             rsp_run_ff, rsp_run_in;
   logic             rsp_exp_ff, rsp_exp_in;
   logic [CNT_W-1:0] rsp_elapsed_ff, rsp_elapsed_in;
   logic [CNT_W-1:0] rsp_remain_ff, rsp_remain_in;
   logic [PCT_W-1:0] rsp_pct_ff, rsp_pct_in;

   // Accept-cycle arithmetic
   logic             accept;
   logic             adv_frame, adv_ms, adv;
   logic [CNT_W-1:0] amount;
   logic [CNT_W:0]   sum;
   logic             reach;

   // Shared divide step
   logic [CNT_W:0]   trial;
   logic             ge;
   logic [CNT_W:0]   trial_sub;
   logic [CNT_W-1:0] rem_next;

   logic [PROD_W-1:0] prod;
   logic              slot_free;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept = req_chan.valid && (state_ff == S_IDLE);

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.fired            = rsp_fired_ff;
   assign rsp_chan.is_running       = rsp_run_ff;
   assign rsp_chan.is_expired       = rsp_exp_ff;
   assign rsp_chan.elapsed_count    = rsp_elapsed_ff;
   assign rsp_chan.remaining_count  = rsp_remain_ff;
   assign rsp_chan.progress_percent = rsp_pct_ff;

   // Advance decode and the one-bit-wider sum
   assign adv_frame = (req_chan.action == ACT_FRAME) && running_ff && !msunit_ff;
   assign adv_ms    = (req_chan.action == ACT_MS) && running_ff && msunit_ff &&
                      (req_chan.delta_ms != '0);
   assign adv       = adv_frame || adv_ms;
   assign amount    = adv_frame ? CNT_W'(1) : req_chan.delta_ms;
   assign sum       = {1'b0, elapsed_ff} + {1'b0, amount};
   assign reach     = (sum >= {1'b0, period_ff});

   // One restoring division step: shift in a dividend bit, subtract if it fits
   assign trial     = {rem_ff, dvd_ff[CNT_W]};
   assign ge        = (trial >= {1'b0, period_ff});
   assign trial_sub = trial - {1'b0, period_ff};
   assign rem_next  = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];

   // elapsed * 100 = elapsed * (64 + 32 + 4)
   assign prod = ({PCT_W'(0), elapsed_ff} << 6) + ({PCT_W'(0), elapsed_ff} << 5) +
                 ({PCT_W'(0), elapsed_ff} << 2);

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // Next-state logic
   always_comb begin
      period_in      = period_ff;
      repeat_in      = repeat_ff;
      msunit_in      = msunit_ff;
      elapsed_in     = elapsed_ff;
      running_in     = running_ff;
      expired_in     = expired_ff;
      fired_in       = fired_ff;
      state_in       = state_ff;
      step_in        = step_ff;
      rem_in         = rem_ff;
      dvd_in         = dvd_ff;
      quo_in         = quo_ff;
      pct_in         = pct_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_fired_in   = rsp_fired_ff;
      rsp_run_in     = rsp_run_ff;
      rsp_exp_in     = rsp_exp_ff;
      rsp_elapsed_in = rsp_elapsed_ff;
      rsp_remain_in  = rsp_remain_ff;
      rsp_pct_in     = rsp_pct_ff;

      // Configuration writes; indexes past the list are dropped
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PERIOD: period_in = csr_write_data;
            CSR_REPEAT: repeat_in = csr_write_data[0];
            CSR_MSUNIT: msunit_in = csr_write_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               fired_in = 1'b0;
               state_in = S_PCT_LOAD;
               case (req_chan.action)
                  ACT_FRAME, ACT_MS: begin
                     if (adv && reach) begin
                        fired_in = 1'b1;
                        if (repeat_ff) begin
                           if (msunit_ff && (period_ff != '0)) begin
                              // Reduce the sum modulo the period in S_MOD
                              rem_in   = '0;
                              dvd_in   = sum;
                              step_in  = STEP_W'(MOD_STEPS);
                              state_in = S_MOD;
                           end else begin
                              elapsed_in = '0;
                           end
                        end else begin
                           elapsed_in = msunit_ff ? period_ff : sum[CNT_W-1:0];
                           running_in = 1'b0;
                           expired_in = 1'b1;
                        end
                     end else if (adv) begin
                        elapsed_in = sum[CNT_W-1:0];
                     end
                  end
                  ACT_START: begin
                     if (period_ff != '0) begin
                        elapsed_in = '0;
                        running_in = 1'b1;
                        expired_in = 1'b0;
                     end
                  end
                  ACT_STOP: begin
                     running_in = 1'b0;
                     expired_in = 1'b0;
                  end
                  ACT_CLEAR: begin
                     elapsed_in = '0;
                     expired_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end

         S_MOD: begin
            rem_in  = rem_next;
            dvd_in  = {dvd_ff[CNT_W-1:0], 1'b0};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               elapsed_in = rem_next;
               state_in   = S_PCT_LOAD;
            end
         end

         S_PCT_LOAD: begin
            if ((period_ff == '0) || (elapsed_ff == '0)) begin
               pct_in   = '0;
               state_in = S_RESULT;
            end else if (elapsed_ff >= period_ff) begin
               pct_in   = PCT_FULL;
               state_in = S_RESULT;
            end else begin
               // Upper product bits are already below the period
               rem_in   = prod[PROD_W-1:PCT_W];
               dvd_in   = {prod[PCT_W-1:0], (CNT_W + 1 - PCT_W)'(0)};
               quo_in   = '0;
               step_in  = STEP_W'(PCT_W);
               state_in = S_PCT;
            end
         end

         S_PCT: begin
            rem_in  = rem_next;
            dvd_in  = {dvd_ff[CNT_W-1:0], 1'b0};
            quo_in  = {quo_ff[PCT_W-2:0], ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               pct_in   = {quo_ff[PCT_W-2:0], ge};
               state_in = S_RESULT;
            end
         end

         S_RESULT: begin
            // Hold until the result slot is free, then fill it
            if (slot_free) begin
               rsp_valid_in   = 1'b1;
               rsp_fired_in   = fired_ff;
               rsp_run_in     = running_ff;
               rsp_exp_in     = expired_ff;
               rsp_elapsed_in = elapsed_ff;
               rsp_remain_in  = (period_ff > elapsed_ff) ? (period_ff - elapsed_ff) : '0;
               rsp_pct_in     = pct_ff;
               state_in       = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= '0;
         repeat_ff    <= 1'b0;
         msunit_ff    <= 1'b0;
         elapsed_ff   <= '0;
         running_ff   <= 1'b0;
         expired_ff   <= 1'b0;
         fired_ff     <= 1'b0;
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         repeat_ff    <= repeat_in;
         msunit_ff    <= msunit_in;
         elapsed_ff   <= elapsed_in;
         running_ff   <= running_in;
         expired_ff   <= expired_in;
         fired_ff     <= fired_in;
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and result payload registers
   always_ff @(posedge clock) begin
      rem_ff         <= rem_in;
      dvd_ff         <= dvd_in;
      quo_ff         <= quo_in;
      pct_ff         <= pct_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_run_ff     <= rsp_run_in;
      rsp_exp_ff     <= rsp_exp_in;
      rsp_elapsed_ff <= rsp_elapsed_in;
      rsp_remain_ff  <= rsp_remain_in;
      rsp_pct_ff     <= rsp_pct_in;
   end

   // An expired one-shot timer is never counting
   a_expired_stopped: assert property (@(posedge clock) disable iff (reset)
      expired_ff |-> !running_ff)
      else $error("expired timer still running");

   // The partial remainder stays below the period while dividing
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MOD) || (state_ff == S_PCT)) |-> (rem_ff < period_ff))
      else $error("divider remainder not below period");

   // A stop transfer leaves the timer halted
   a_stop_halts: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.action == ACT_STOP)) |=> (!running_ff && !expired_ff))
      else $error("stop did not halt the timer");

   // A delivered percentage never exceeds full
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pct_ff <= PCT_FULL))
      else $error("progress above 100");

endmodule
